// File: hw/rtl/scfp_pkg.sv
// ----------------------------------------------------------------------------
// scfp_pkg: shared types and constants of the servo command frame parser
// Holds the parse phase encoding, the frame event bundle passed from the
// parser to the servo bank, and the reset values and command codes.
// ----------------------------------------------------------------------------
package scfp_pkg;

	localparam int unsigned NUM_SERVOS_DEF = 4;
	localparam int unsigned NUM_CHANNELS   = 4;
	localparam int unsigned CAPTURE_DEPTH  = 3;

	localparam logic [15:0] OFFSET_RESET = 16'd1000;

	// command codes
	localparam logic [7:0] CMD_FIRST     = 8'd1;
	localparam logic [7:0] CMD_SET_SERVO = 8'd2;
	localparam logic [7:0] CMD_LAST      = 8'd4;

	// register map (word index taken from paddr[2])
	localparam logic REG_PULSE_OFFSET = 1'b0;

	// stream payload widths
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 80;

	typedef enum logic [1:0] {
		PH_CMD  = 2'd0,
		PH_LEN  = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	// per-byte frame event, valid in the cycle the byte is accepted
	typedef struct packed {
		logic        done;
		logic [7:0]  command;
		logic        unknown;
		logic        set_servo;
		logic [7:0]  servo;
		logic [15:0] width;
	} frame_evt_t;

endpackage

// File: hw/rtl/scfp_parser.sv
// ----------------------------------------------------------------------------
// scfp_parser: frame parser and capture store
// Walks command / length / data bytes, keeps the leading data bytes and
// reports the end of each frame together with the decoded servo request.
// ----------------------------------------------------------------------------
module scfp_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	input  logic [7:0]              byte_in,
	output scfp_pkg::frame_evt_t    evt
);

	scfp_pkg::phase_t phase_q, phase_nxt;
	logic [7:0] cmd_q;
	logic [7:0] rem_q;
	logic [7:0] idx_q;
	logic [7:0] cap_q [scfp_pkg::CAPTURE_DEPTH];

	logic [7:0] rem_dec;
	logic [7:0] idx_inc;
	logic       data_last;
	logic       keep_byte;
	logic       done;
	logic [7:0] cmd_nxt;

	assign rem_dec   = rem_q - 8'd1;
	assign idx_inc   = idx_q + 8'd1;
	assign data_last = (rem_dec == 8'd0);

	// next phase
	always_comb begin
		unique case (phase_q)
			scfp_pkg::PH_LEN:  phase_nxt = (byte_in == 8'd0) ? scfp_pkg::PH_CMD
			                                                 : scfp_pkg::PH_DATA;
			scfp_pkg::PH_DATA: phase_nxt = data_last ? scfp_pkg::PH_CMD
			                                         : scfp_pkg::PH_DATA;
			default:           phase_nxt = scfp_pkg::PH_LEN;
		endcase
	end

	// per-phase decode
	always_comb begin
		done      = 1'b0;
		keep_byte = 1'b0;
		cmd_nxt   = cmd_q;
		unique case (phase_q)
			scfp_pkg::PH_LEN:  done = (byte_in == 8'd0);
			scfp_pkg::PH_DATA: begin
				done      = data_last;
				keep_byte = !data_last;
			end
			default:           cmd_nxt = byte_in;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= scfp_pkg::PH_CMD;
			cmd_q   <= '0;
			rem_q   <= '0;
			idx_q   <= '0;
			for (int i = 0; i < scfp_pkg::CAPTURE_DEPTH; i++) begin
				cap_q[i] <= '0;
			end
		end else if (byte_valid) begin
			phase_q <= phase_nxt;
			cmd_q   <= cmd_nxt;
			if (phase_q == scfp_pkg::PH_LEN) begin
				rem_q <= byte_in;
			end else if (phase_q == scfp_pkg::PH_DATA) begin
				rem_q <= rem_dec;
				if (data_last) begin
					idx_q <= '0;
				end else begin
					idx_q <= idx_inc;
				end
			end
			// kept byte at idx, terminating zero at idx+1; beyond depth dropped
			if (keep_byte) begin
				for (int i = 0; i < scfp_pkg::CAPTURE_DEPTH; i++) begin
					if (idx_q == 8'(i)) begin
						cap_q[i] <= byte_in;
					end else if (idx_inc == 8'(i)) begin
						cap_q[i] <= 8'd0;
					end
				end
			end
		end
	end

	always_comb begin
		evt.done      = done;
		evt.command   = cmd_nxt;
		evt.unknown   = done && ((cmd_nxt < scfp_pkg::CMD_FIRST) ||
		                         (cmd_nxt > scfp_pkg::CMD_LAST));
		evt.set_servo = done && (cmd_nxt == scfp_pkg::CMD_SET_SERVO);
		evt.servo     = cap_q[0];
		evt.width     = {cap_q[1], cap_q[2]};
	end

endmodule

// File: hw/rtl/servo_command_frame_parser.sv
// ----------------------------------------------------------------------------
// servo_command_frame_parser: servo command frame parser, top level
// Parses a byte stream of command frames, updates servo pulse widths on
// command 2 and reports per-channel compare values after every byte.
// ----------------------------------------------------------------------------
//
// Channel    Dir  Handshake                 Payload
// s_*        in   s_tvalid / s_tready       s_tdata[7:0] = data_byte
// m_*        out  m_tvalid / m_tready       m_tlast = frame_done, m_tdata (see port)
// APB        in   psel & penable & pwrite   0x0: pulse_offset[15:0]
//
// Cycles: one byte per clock sustained while m_tready keeps up; the result of
// a byte appears in the output register on the cycle after its transaction.
// All parsing, the servo write and the four offset adders sit between the
// input handshake and that register.
// Reset: arst_n clears parse state, capture bytes and pulse widths, and sets
// pulse_offset to 1000.
// Stalls: s_tready is high whenever the output register is empty or being
// drained in the same cycle, so input is held off only while a result waits
// with m_tready low, and resumes with no bubble once it is taken.
//
module servo_command_frame_parser #(
	parameter int unsigned NUM_SERVOS = scfp_pkg::NUM_SERVOS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte

	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_tlast,   // frame_done
	// [7:0] command_code, [8] unknown_command, [9] servo_written,
	// [10] bad_servo_index, [26:11] compare_ch0, [42:27] compare_ch1,
	// [58:43] compare_ch2, [74:59] compare_ch3, [79:75] zero
	output logic [79:0] m_tdata,

	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	scfp_pkg::frame_evt_t evt;

	logic        in_xact;
	logic        cfg_wr;
	logic [15:0] offset_q;
	logic [15:0] pw_q   [NUM_SERVOS];
	logic [15:0] pw_nxt [NUM_SERVOS];
	logic [15:0] cmp    [scfp_pkg::NUM_CHANNELS];
	logic        servo_ok;
	logic        written;
	logic        bad;

	logic        m_tvalid_q;
	logic        m_tlast_q;
	logic [79:0] m_tdata_q;

	// ------------------------------------------------------------------
	// handshakes
	// ------------------------------------------------------------------
	assign s_tready = !m_tvalid_q || m_tready;
	assign in_xact  = s_tvalid && s_tready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
	                (paddr[2] == scfp_pkg::REG_PULSE_OFFSET);
	assign prdata = (paddr[2] == scfp_pkg::REG_PULSE_OFFSET) ? {16'd0, offset_q}
	                                                         : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= scfp_pkg::OFFSET_RESET;
		end else if (cfg_wr) begin
			offset_q <= pwdata[15:0];
		end
	end

	// ------------------------------------------------------------------
	// frame parsing
	// ------------------------------------------------------------------
	scfp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (in_xact),
		.byte_in    (s_tdata),
		.evt        (evt)
	);

	// ------------------------------------------------------------------
	// servo bank: index check against the servo count
	// ------------------------------------------------------------------
	assign servo_ok = (evt.servo < 8'(NUM_SERVOS));
	assign written  = evt.set_servo && servo_ok;
	assign bad      = evt.set_servo && !servo_ok;

	always_comb begin
		for (int s = 0; s < NUM_SERVOS; s++) begin
			pw_nxt[s] = (written && (evt.servo == 8'(s))) ? evt.width : pw_q[s];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SERVOS; s++) begin
				pw_q[s] <= '0;
			end
		end else if (in_xact) begin
			for (int s = 0; s < NUM_SERVOS; s++) begin
				pw_q[s] <= pw_nxt[s];
			end
		end
	end

	// compare values use the widths as updated by this byte;
	// channels without a servo report the offset alone
	always_comb begin
		for (int k = 0; k < scfp_pkg::NUM_CHANNELS; k++) begin
			if (k < NUM_SERVOS) begin
				cmp[k] = offset_q + pw_nxt[k];
			end else begin
				cmp[k] = offset_q;
			end
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xact) begin
			m_tlast_q <= evt.done;
			m_tdata_q <= {5'd0, cmp[3], cmp[2], cmp[1], cmp[0],
			              bad, written, evt.unknown, evt.command};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = m_tdata_q;

endmodule
